// ----- hw/rtl/tsh_pkg.sv -----
// Shared types, constants and trit helpers for the ternary sponge hash unit.
`default_nettype none

package tsh_pkg;

    // Geometry of the sponge
    localparam int STATE_TRITS      = 729;
    localparam int RATE_TRITS       = 243;
    localparam int WALK_UP          = 364;
    localparam int DEF_ROUND_COUNT  = 27;
    localparam int POS_W            = 8;
    localparam int IDX_W            = 10;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_ABSORB  = 2'd0;
    localparam logic [1:0] OP_SQUEEZE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Balanced trit encodings, two's complement
    localparam logic [1:0] TRIT_ZERO = 2'b00;
    localparam logic [1:0] TRIT_POS  = 2'b01;
    localparam logic [1:0] TRIT_NEG  = 2'b11;

    // Round truth table, indexed by (a+1) + 3*(b+1)
    localparam logic [1:0] MIX_TABLE [9] = '{
        TRIT_POS, TRIT_ZERO, TRIT_NEG,
        TRIT_POS, TRIT_NEG,  TRIT_ZERO,
        TRIT_NEG, TRIT_POS,  TRIT_ZERO
    };

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic run_round;
    } tsh_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic perm_req;
    } tsh_status_t;

    // Raw input pattern to a stored trit; the pattern -2 saturates to -1
    function automatic logic [1:0] trit_decode(input logic [1:0] raw);
        logic [1:0] t;
        case (raw)
            2'b00:   t = TRIT_ZERO;
            2'b01:   t = TRIT_POS;
            default: t = TRIT_NEG;
        endcase
        return t;
    endfunction

    // Stored trit plus one, range 0..2
    function automatic logic [3:0] trit_bias(input logic [1:0] t);
        logic [3:0] v;
        case (t)
            TRIT_ZERO: v = 4'd1;
            TRIT_POS:  v = 4'd2;
            default:   v = 4'd0;
        endcase
        return v;
    endfunction

    // One cell of a round: new trit from two snapshot trits
    function automatic logic [1:0] mix_lookup(input logic [1:0] a, input logic [1:0] b);
        logic [3:0] idx;
        idx = trit_bias(a) + 4'(3 * trit_bias(b));
        return MIX_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tsh_ctrl.sv -----
// Controller state machine: request handshake, output valid and round sequencing.
`default_nettype none

module tsh_ctrl
    import tsh_pkg::*;
#(
    parameter int ROUND_COUNT = DEF_ROUND_COUNT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire tsh_status_t status,
    output tsh_cmd_t         cmd
);

    localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_ROUND = 1'b1;

    logic          state_reg, state_next;
    logic [RW-1:0] round_cnt_reg, round_cnt_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          accept;

    // Take a request only when idle and the output slot is free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    assign cmd.accept    = accept;
    assign cmd.run_round = (state_reg == ST_ROUND);

    // Next state and round counter
    always_comb
    begin
        state_next     = state_reg;
        round_cnt_next = round_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.perm_req)
                begin
                    state_next     = ST_ROUND;
                    round_cnt_next = RW'(ROUND_COUNT - 1);
                end
            end
            ST_ROUND:
            begin
                if (round_cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    round_cnt_next = round_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set by each request, cleared when taken
    always_comb
    begin
        if (accept)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tsh_datapath.sv -----
// Datapath: 729-trit sponge state, block position, round lanes and result register.
`default_nettype none

module tsh_datapath
    import tsh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tsh_cmd_t    cmd,
    input  wire logic [1:0]  op,
    input  wire logic [1:0]  trit_raw,
    input  wire logic        last_of_call,
    output tsh_status_t      status,
    output logic [1:0]       trit_out,
    output logic             out_valid,
    output logic             hash_done
);

    logic [1:0]       state_reg [STATE_TRITS];
    logic [1:0]       round_next [STATE_TRITS];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] pos_idx;
    logic             block_end;
    logic             is_absorb, is_squeeze, is_clear;
    logic [1:0]       trit_out_reg;
    logic             out_valid_reg, hash_done_reg;

    assign is_absorb  = (op == OP_ABSORB);
    assign is_squeeze = (op == OP_SQUEEZE);
    assign is_clear   = (op == OP_CLEAR);
    assign pos_idx    = {{(IDX_W - POS_W){1'b0}}, pos_reg};
    assign block_end  = (pos_reg == POS_W'(RATE_TRITS - 1));

    // A transform follows a full block, or a last-marked absorb trit
    assign status.perm_req = (is_absorb && (block_end || last_of_call))
                           || (is_squeeze && block_end);

    // Round lanes: the walk is a step of +364 mod 729, identical every round
    for (genvar s = 0; s < STATE_TRITS; s++)
    begin : g_lane
        localparam int PA = (WALK_UP * s) % STATE_TRITS;
        localparam int PB = (WALK_UP * (s + 1)) % STATE_TRITS;
        assign round_next[s] = mix_lookup(state_reg[PA], state_reg[PB]);
    end

    // Block position
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.accept)
        begin
            if (is_clear || status.perm_req)
            begin
                pos_next = '0;
            end
            else if (is_absorb || is_squeeze)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Sponge state: clear, round update, or absorb write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STATE_TRITS; i++)
            begin
                state_reg[i] <= TRIT_ZERO;
            end
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cmd.run_round)
            begin
                for (int i = 0; i < STATE_TRITS; i++)
                begin
                    state_reg[i] <= round_next[i];
                end
            end
            else if (cmd.accept && is_clear)
            begin
                for (int i = 0; i < STATE_TRITS; i++)
                begin
                    state_reg[i] <= TRIT_ZERO;
                end
            end
            else if (cmd.accept && is_absorb)
            begin
                state_reg[pos_idx] <= trit_decode(trit_raw);
            end
        end
    end

    // Result register, loaded with every request
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            trit_out_reg  <= is_squeeze ? state_reg[pos_idx] : TRIT_ZERO;
            out_valid_reg <= is_squeeze;
            hash_done_reg <= is_squeeze && block_end;
        end
    end

    assign trit_out  = trit_out_reg;
    assign out_valid = out_valid_reg;
    assign hash_done = hash_done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ternary_sponge_hash_unit.sv -----
// Top level of the ternary sponge hash unit: stream ports, controller and datapath.
//
// Input stream: one request per trit. s_tuser is the operation (absorb, squeeze,
// clear), s_tdata[1:0] the trit to absorb, s_tlast marks the final trit of an
// absorb call. Every request returns exactly one result on the output stream:
// m_tdata[1:0] the squeezed trit (zero for other operations), m_tuser set when
// it carries a squeezed trit, m_tlast set on the 243rd squeezed trit.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle, except that a request that closes a block
// (243rd trit, or a last-marked absorb trit) starts a transform, a run of rounds
// that each update all 729 lanes in parallel, during which s_tready is low.
// A stalled receiver holds the result register; one further request can be
// accepted only in the cycle the pending result is taken.
// Reset clears the sponge state, block position and output valid at once.
`default_nettype none

module ternary_sponge_hash_unit
    import tsh_pkg::*;
#(
    parameter int ROUND_COUNT = DEF_ROUND_COUNT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [1:0] trit_in, [7:2] zero
    input  wire logic [1:0] s_tuser,   // [1:0] op
    input  wire logic       s_tlast,   // last_of_call
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [1:0] trit_out, [7:2] zero
    output logic            m_tuser,   // out_valid
    output logic            m_tlast    // hash_done
);

    tsh_cmd_t    cmd;
    tsh_status_t status;
    logic [1:0]  trit_out;

    tsh_ctrl #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tsh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (s_tuser),
        .trit_raw     (s_tdata[1:0]),
        .last_of_call (s_tlast),
        .status       (status),
        .trit_out     (trit_out),
        .out_valid    (m_tuser),
        .hash_done    (m_tlast)
    );

    assign m_tdata = {6'b0, trit_out};

endmodule

`default_nettype wire
